// ===== rtl/alir_pkg.sv =====
// Shared types, codes and widths for the array list insert/remove unit.
`default_nettype none
package alir_pkg;

  // Default number of list cells.
  localparam int DEPTH_DEF = 64;

  // Fixed field widths of the request and response words.
  localparam int KIND_W   = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    K_INSERT   = 3'd0,
    K_REMOVE   = 3'd1,
    K_READ     = 3'd2,
    K_TRAV_FWD = 3'd3,
    K_TRAV_BWD = 3'd4
  } kind_t;

  // Status codes carried in each response word.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  // Shift command broadcast from the control to every cell.
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
  } shift_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/alir_req_if.sv =====
// Request channel: operation kind, position and value.
`default_nettype none
interface alir_req_if;
  logic                              valid;
  logic                              ready;
  logic [alir_pkg::KIND_W-1:0]       kind;
  logic [alir_pkg::POS_W-1:0]        position;
  logic signed [alir_pkg::DATA_W-1:0] value;

  modport source(output valid, kind, position, value, input ready);
  modport sink(input valid, kind, position, value, output ready);
endinterface
`default_nettype wire

// ===== rtl/alir_rsp_if.sv =====
// Response channel: status, data, last flag and entry count.
`default_nettype none
interface alir_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [alir_pkg::STATUS_W-1:0]      status;
  logic signed [alir_pkg::DATA_W-1:0] data;
  logic                               last;
  logic [alir_pkg::POS_W-1:0]         count;

  modport source(output valid, status, data, last, count, input ready);
  modport sink(input valid, status, data, last, count, output ready);
endinterface
`default_nettype wire

// ===== rtl/array_list_insert_remove_unit.sv =====
// Insert, remove and read: the request word is decoded and the cells shift in the accept
// cycle, and the response word is registered for the next cycle.
// A traversal is accepted, then sends one word per cycle from the read bus while each word is
// taken, and holds off new requests until its last word is registered.
// A new request is taken only when no response word waits or in the cycle that word is taken.
// Reset (synchronous) empties the list; cell contents are left as they are.
`default_nettype none
module array_list_insert_remove_unit #(
  parameter int DEPTH = alir_pkg::DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst,
  alir_req_if.sink    req,
  alir_rsp_if.source  rsp
);
  import alir_pkg::*;

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  typedef enum logic {
    S_IDLE,
    S_TRAV
  } state_t;

  state_t                   state;
  logic [CNT_W-1:0]         count;
  logic [IDX_W-1:0]         trav_idx;
  logic                     trav_fwd;
  logic                     out_valid;
  status_t                  out_status;
  logic signed [DATA_W-1:0] out_data;
  logic                     out_last;
  logic [POS_W-1:0]         out_count;

  logic                     req_fire;
  logic                     out_free;
  logic [CMP_W-1:0]         pos_x;
  logic [CMP_W-1:0]         cnt_x;
  logic [CNT_W-1:0]         cnt_m1;
  logic                     is_full;
  logic                     is_empty;
  logic                     ins_bad;
  logic                     acc_bad;
  logic                     trav_end;
  logic [IDX_W-1:0]         sel_idx;
  logic signed [DATA_W-1:0] rd_data;
  shift_cmd_t               cmd;

  // Handshake and position checks.
  always_comb begin
    out_free  = !out_valid || rsp.ready;
    req.ready = (state == S_IDLE) && out_free;
    req_fire  = req.valid && req.ready;
    pos_x     = CMP_W'(req.position);
    cnt_x     = CMP_W'(count);
    cnt_m1    = count - CNT_W'(1);
    is_full   = (count == CNT_FULL);
    is_empty  = (count == '0);
    ins_bad   = pos_x > cnt_x;
    acc_bad   = pos_x >= cnt_x;
    trav_end  = trav_fwd ? (trav_idx == IDX_W'(cnt_m1)) : (trav_idx == '0);
    sel_idx   = (state == S_TRAV) ? trav_idx : IDX_W'(req.position);
  end

  // Shift command to the cells for a valid insert or remove.
  always_comb begin
    cmd     = '0;
    cmd.pos = req.position;
    cmd.val = req.value;
    if (req_fire) begin
      case (req.kind)
        K_INSERT: cmd.ins = !is_full && !ins_bad;
        K_REMOVE: cmd.rem = !is_empty && !acc_bad;
        default:  cmd     = cmd;
      endcase
    end
  end

  alir_row #(
    .DEPTH(DEPTH),
    .IDX_W(IDX_W)
  ) u_row (
    .clk    (clk),
    .cmd    (cmd),
    .sel_idx(sel_idx),
    .rd_data(rd_data)
  );

  // Control state, entry count and the registered response word.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            out_valid  <= 1'b1;
            out_last   <= 1'b1;
            out_data   <= '0;
            out_status <= ST_OK;
            out_count  <= POS_W'(count);
            case (req.kind)
              K_INSERT: begin
                if (is_full) begin
                  out_status <= ST_FULL;
                end else if (ins_bad) begin
                  out_status <= ST_BADPOS;
                end else begin
                  count     <= count + CNT_W'(1);
                  out_count <= POS_W'(count + CNT_W'(1));
                end
              end
              K_REMOVE: begin
                if (is_empty) begin
                  out_status <= ST_EMPTY;
                end else if (acc_bad) begin
                  out_status <= ST_BADPOS;
                end else begin
                  count     <= cnt_m1;
                  out_count <= POS_W'(cnt_m1);
                end
              end
              K_READ: begin
                if (is_empty) begin
                  out_status <= ST_EMPTY;
                end else if (acc_bad) begin
                  out_status <= ST_BADPOS;
                end else begin
                  out_data <= rd_data;
                end
              end
              K_TRAV_FWD, K_TRAV_BWD: begin
                if (is_empty) begin
                  out_status <= ST_EMPTY;
                end else begin
                  out_valid <= 1'b0;
                  state     <= S_TRAV;
                  trav_fwd  <= (req.kind == K_TRAV_FWD);
                  trav_idx  <= (req.kind == K_TRAV_FWD) ? '0 : IDX_W'(cnt_m1);
                end
              end
              default: begin
                out_status <= ST_BADPOS;
              end
            endcase
          end
        end
        S_TRAV: begin
          // One entry per free output slot, walking the read index.
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= ST_OK;
            out_data   <= rd_data;
            out_last   <= trav_end;
            out_count  <= POS_W'(count);
            if (trav_end) begin
              state <= S_IDLE;
            end else if (trav_fwd) begin
              trav_idx <= trav_idx + IDX_W'(1);
            end else begin
              trav_idx <= trav_idx - IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid  = out_valid;
  assign rsp.status = out_status;
  assign rsp.data   = out_data;
  assign rsp.last   = out_last;
  assign rsp.count  = out_count;

endmodule
`default_nettype wire

// ===== rtl/alir_cell.sv =====
// One list cell: holds an entry and takes its neighbor's entry on a shift, or the new value on an insert at its index.
`default_nettype none
module alir_cell #(
  parameter int INDEX = 0,
  parameter int IDX_W = 6
) (
  input  wire logic                               clk,
  input  wire alir_pkg::shift_cmd_t               cmd,
  input  wire logic signed [alir_pkg::DATA_W-1:0] left_data,
  input  wire logic signed [alir_pkg::DATA_W-1:0] right_data,
  input  wire logic [IDX_W-1:0]                   sel_idx,
  output logic signed [alir_pkg::DATA_W-1:0]      data,
  output logic signed [alir_pkg::DATA_W-1:0]      rd_data
);
  import alir_pkg::*;

  localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam logic [CMP_W-1:0] MY_IDX  = CMP_W'(INDEX);
  localparam logic [IDX_W-1:0] SEL_IDX = IDX_W'(INDEX);

  logic [CMP_W-1:0] pos_ext;

  assign pos_ext = CMP_W'(cmd.pos);

  // Insert opens a gap at the position and writes the value into it; remove closes it.
  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (MY_IDX > pos_ext) begin
        data <= left_data;
      end else if (MY_IDX == pos_ext) begin
        data <= cmd.val;
      end
    end else if (cmd.rem) begin
      if (MY_IDX >= pos_ext) begin
        data <= right_data;
      end
    end
  end

  // Drive the shared read bus only when selected.
  assign rd_data = (sel_idx == SEL_IDX) ? data : '0;

endmodule
`default_nettype wire

// ===== rtl/alir_row.sv =====
// Row of list cells chained left to right, with a read bus ORed from the cells, at most one selected.
`default_nettype none
module alir_row #(
  parameter int DEPTH = alir_pkg::DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  wire logic                               clk,
  input  wire alir_pkg::shift_cmd_t               cmd,
  input  wire logic [IDX_W-1:0]                   sel_idx,
  output logic signed [alir_pkg::DATA_W-1:0]      rd_data
);
  import alir_pkg::*;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_rd   [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_end
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    alir_cell #(
      .INDEX(i),
      .IDX_W(IDX_W)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .left_data (left_in),
      .right_data(right_in),
      .sel_idx   (sel_idx),
      .data      (cell_data[i]),
      .rd_data   (cell_rd[i])
    );
  end

  // At most one cell drives a nonzero word onto the bus.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_data = rd_data | cell_rd[i];
    end
  end

endmodule
`default_nettype wire
